// ===== src/urbrf_pkg.sv =====
// Package for the UART register block with receive FIFO.
// Register indexes, status bit masks, control bit positions, transaction codes, channel modes, reset values.
// No dependencies.
package urbrf_pkg;

  localparam int unsigned RxDepthDef = 16;
  localparam int unsigned NRegs      = 18;
  localparam int unsigned RegIdxW    = 5;

  // Register word indexes
  localparam logic [RegIdxW-1:0] R_CR    = 5'd0;
  localparam logic [RegIdxW-1:0] R_MR    = 5'd1;
  localparam logic [RegIdxW-1:0] R_IER   = 5'd2;
  localparam logic [RegIdxW-1:0] R_IDR   = 5'd3;
  localparam logic [RegIdxW-1:0] R_IMR   = 5'd4;
  localparam logic [RegIdxW-1:0] R_CISR  = 5'd5;
  localparam logic [RegIdxW-1:0] R_BRGR  = 5'd6;
  localparam logic [RegIdxW-1:0] R_RTRIG = 5'd8;
  localparam logic [RegIdxW-1:0] R_SR    = 5'd11;
  localparam logic [RegIdxW-1:0] R_DATA  = 5'd12;
  localparam logic [RegIdxW-1:0] R_TTRIG = 5'd17;

  // Status register bits
  localparam logic [31:0] SR_RTRIG   = 32'h0000_0001;
  localparam logic [31:0] SR_REMPTY  = 32'h0000_0002;
  localparam logic [31:0] SR_RFUL    = 32'h0000_0004;
  localparam logic [31:0] SR_TEMPTY  = 32'h0000_0008;
  localparam logic [31:0] SR_TFUL    = 32'h0000_0010;
  localparam logic [31:0] SR_TO_CISR = 32'h0000_001F;
  localparam logic [31:0] INT_ROVR   = 32'h0000_0020;
  localparam logic [31:0] INT_TOUT   = 32'h0000_0100;

  // Control register bit positions
  localparam int unsigned CR_RXRST    = 0;
  localparam int unsigned CR_TXRST    = 1;
  localparam int unsigned CR_RX_EN    = 2;
  localparam int unsigned CR_RX_DIS   = 3;
  localparam int unsigned CR_TX_EN    = 4;
  localparam int unsigned CR_TX_DIS   = 5;
  localparam int unsigned CR_STARTBRK = 7;
  localparam int unsigned CR_STOPBRK  = 8;

  // Reset values
  localparam logic [31:0] CR_RESET    = 32'h0000_0128;
  localparam logic [31:0] TRIG_RESET  = 32'h0000_0020;
  localparam logic [31:0] BRGR_RESET  = 32'h0000_000F;
  localparam logic [31:0] SR_RESET    = 32'h0000_000A;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_RX_BYTE = 3'd2,
    OP_BREAK   = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ECHO   = 2'd1,
    MODE_LOCAL  = 2'd2,
    MODE_REMOTE = 2'd3
  } chan_mode_e;

  function automatic logic [31:0] reg_reset(input logic [RegIdxW-1:0] idx);
    logic [31:0] val;
    val = '0;
    if (idx == R_CR) begin
      val = CR_RESET;
    end else if (idx == R_BRGR) begin
      val = BRGR_RESET;
    end else if (idx == R_RTRIG || idx == R_TTRIG) begin
      val = TRIG_RESET;
    end else if (idx == R_SR) begin
      val = SR_RESET;
    end
    return val;
  endfunction

endpackage

// ===== src/urbrf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module urbrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/uart_register_block_rx_fifo.sv =====
// UART register block: bus register file, receive FIFO, interrupt status.
// Depends on urbrf_pkg and urbrf_ram.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   tvalid/tready               tuser: op; tdata: addr, wdata, rx_byte
// m_axis    out  tvalid/tready               tdata: read_data, irq, tx_valid,
//                                            tx_byte, break_request
//
// One transaction per cycle while the output is not stalled, one result per
// transaction: the register file, FIFO pointers and status update at the accepting
// edge, and the result register (plus the FIFO RAM read register) holds the result.
// Input is accepted while the result register is empty or being drained.
// Reset is asynchronous active low; it restores the register file and empties the FIFO.
module uart_register_block_rx_fifo
  import urbrf_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RxDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] op
  input  logic [55:0] s_axis_tdata_i,   // [9:0] addr, [41:10] wdata, [49:42] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [31:0] read_data, [32] irq, [33] tx_valid,
                                        // [41:34] tx_byte, [42] break_request
);

  localparam int unsigned PtrW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RX_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RX_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(RX_DEPTH);

  // Input fields
  logic [2:0]  op;
  logic [9:0]  addr;
  logic [31:0] wdata;
  logic [7:0]  rx_byte;
  logic        accept;

  assign op      = s_axis_tuser_i;
  assign addr    = s_axis_tdata_i[9:0];
  assign wdata   = s_axis_tdata_i[41:10];
  assign rx_byte = s_axis_tdata_i[49:42];

  // State
  logic [31:0]     regs_q [NRegs];
  logic [31:0]     regs_d [NRegs];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Result register
  logic        out_valid_q;
  logic [31:0] rdata_q, rdata_d;
  logic        irq_q, irq_d;
  logic        txv_q, txv_d;
  logic [7:0]  txb_q, txb_d;
  logic        brk_q, brk_d;
  logic        pop_sel_q;

  // FIFO control
  logic        push_req, push_we, pop_hit;
  logic [7:0]  push_byte;
  logic [7:0]  ram_rdata;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    logic [31:0]     cr, sr, cisr, imr, rtrig;
    logic [RegIdxW-1:0] ridx;
    logic            mapped, rx_en, tx_en, do_refresh;
    chan_mode_e      mode;

    for (int i = 0; i < NRegs; i++) begin
      regs_d[i] = regs_q[i];
    end
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    rdata_d   = '0;
    txv_d     = 1'b0;
    txb_d     = '0;
    brk_d     = 1'b0;
    push_req  = 1'b0;
    push_we   = 1'b0;
    push_byte = '0;
    pop_hit   = 1'b0;
    do_refresh = 1'b0;

    cr    = regs_q[R_CR];
    sr    = regs_q[R_SR];
    cisr  = regs_q[R_CISR];
    imr   = regs_q[R_IMR];
    rtrig = regs_q[R_RTRIG];
    ridx  = addr[RegIdxW-1:0];
    mapped = addr < 10'(NRegs);
    mode  = chan_mode_e'(regs_q[R_MR][9:8]);
    rx_en = cr[CR_RX_EN] && !cr[CR_RX_DIS];
    tx_en = cr[CR_TX_EN] && !cr[CR_TX_DIS];

    unique case (op)
      OP_READ: begin
        if (mapped && ridx == R_DATA) begin
          if (rx_en) begin
            sr = sr & ~SR_RFUL;
            if (cnt_q != '0) begin
              pop_hit = 1'b1;
              cnt_d   = cnt_q - 1'b1;
              rp_d    = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
              if (cnt_d == '0) begin
                sr = sr | SR_REMPTY;
              end
            end else begin
              sr = sr | SR_REMPTY;
            end
            if (32'(cnt_d) < rtrig) begin
              sr = sr & ~SR_RTRIG;
            end
            cisr = cisr | (sr & SR_TO_CISR);
          end
        end else if (mapped) begin
          rdata_d = regs_q[ridx];
        end
      end
      OP_WRITE: begin
        if (mapped) begin
          if (ridx == R_IER) begin
            imr = imr | wdata;
          end else if (ridx == R_IDR) begin
            imr = imr & ~wdata;
          end else if (ridx == R_IMR) begin
            // read only
          end else if (ridx == R_CISR) begin
            cisr = cisr & ~wdata;
          end else if (ridx == R_DATA) begin
            if (mode == MODE_NORMAL) begin
              if (tx_en) begin
                txv_d = 1'b1;
                txb_d = wdata[7:0];
              end
            end else if (mode == MODE_LOCAL) begin
              push_req  = 1'b1;
              push_byte = wdata[7:0];
            end
          end else if (ridx == R_SR) begin
            sr = wdata;
          end else begin
            regs_d[ridx] = wdata;
          end
          if (ridx == R_CR) begin
            cr = wdata;
            if (cr[CR_TXRST]) begin
              sr = (sr | SR_TEMPTY) & ~SR_TFUL;
            end
            if (cr[CR_RXRST]) begin
              wp_d  = '0;
              rp_d  = '0;
              cnt_d = '0;
              sr    = (sr | SR_REMPTY) & ~SR_RFUL;
            end
            cr[CR_TXRST] = 1'b0;
            cr[CR_RXRST] = 1'b0;
            if (cr[CR_TX_EN] && !cr[CR_TX_DIS]) begin
              sr   = sr | SR_TEMPTY;
              cisr = cisr | (sr & SR_TO_CISR);
            end
            brk_d = cr[CR_STARTBRK] && !cr[CR_STOPBRK];
            regs_d[R_CR] = cr;
          end
        end
      end
      OP_RX_BYTE: begin
        if (mode == MODE_NORMAL || mode == MODE_ECHO) begin
          push_req  = 1'b1;
          push_byte = rx_byte;
        end
        if ((mode == MODE_REMOTE || mode == MODE_ECHO) && tx_en) begin
          txv_d = 1'b1;
          txb_d = rx_byte;
        end
      end
      OP_BREAK: begin
        push_req   = 1'b1;
        do_refresh = 1'b1;
      end
      OP_TIMEOUT: begin
        cisr       = cisr | INT_TOUT;
        do_refresh = 1'b1;
      end
      default: begin
      end
    endcase

    // FIFO push shared by line bytes, breaks and local loopback
    if (push_req && rx_en) begin
      sr = sr & ~SR_REMPTY;
      if (cnt_q >= CntFull) begin
        cisr = cisr | INT_ROVR;
      end else begin
        push_we = 1'b1;
        wp_d    = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_d == CntFull) begin
          sr = sr | SR_RFUL;
        end else if (32'(cnt_d) >= rtrig) begin
          sr = sr | SR_RTRIG;
        end
      end
      cisr = cisr | (sr & SR_TO_CISR);
    end

    if (do_refresh) begin
      cisr = cisr | (sr & SR_TO_CISR);
    end

    regs_d[R_SR]   = sr;
    regs_d[R_CISR] = cisr;
    regs_d[R_IMR]  = imr;
    irq_d = |(imr & cisr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NRegs; i++) begin
        regs_q[i] <= reg_reset(RegIdxW'(i));
      end
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pop_sel_q   <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < NRegs; i++) begin
          regs_q[i] <= regs_d[i];
        end
        wp_q        <= wp_d;
        rp_q        <= rp_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
        pop_sel_q   <= pop_hit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      txv_q   <= txv_d;
      txb_q   <= txb_d;
      brk_q   <= brk_d;
    end
  end

  urbrf_ram #(
    .Width (8),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (accept && push_we),
    .waddr_i (wp_q),
    .wdata_i (push_byte),
    .re_i    (accept && pop_hit),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, brk_q, txb_q, txv_q, irq_q,
                            pop_sel_q ? {24'b0, ram_rdata} : rdata_q};

  // Fill count stays within the FIFO depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("rx fill count beyond depth");

  // A pop is only issued when the FIFO holds data
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_hit |-> cnt_q != '0)
    else $error("pop from empty rx fifo");

  // A push into a full FIFO leaves the pointers untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && push_req && cnt_q == CntFull && op != OP_WRITE) |=>
      ($stable(cnt_q) && $stable(wp_q)))
    else $error("overrun changed fifo pointers");

  // Stall on input only while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result register");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for uart_register_block_rx_fifo.
// Holds its own register and FIFO predictor and uses only urbrf_pkg and the block.
module tb_top;
  import urbrf_pkg::*;

  localparam int unsigned FifoDepth  = RxDepthDef;
  localparam int unsigned RandItems  = 1120;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrint   = 40;
  localparam logic [31:0] CrRun      = (32'd1 << CR_RX_EN) | (32'd1 << CR_TX_EN);

  typedef struct packed {
    op_e         op;
    logic [9:0]  addr;
    logic [31:0] wdata;
    logic [7:0]  rx_byte;
  } uart_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        brk;
  } uart_result_t;

  typedef struct {
    uart_item_t   it;
    bit           typed;
    uart_result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser;   // [2:0] op
  logic [55:0] s_axis_tdata;   // [9:0] addr, [41:10] wdata, [49:42] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] read_data, [32] irq, [33] tx_valid,
                               // [41:34] tx_byte, [42] break_request

  // predictor state
  logic [31:0]  shadow_regs [NRegs];
  logic [7:0]   rx_mem [FifoDepth];
  int unsigned  rx_wr_ptr;
  int unsigned  rx_level;

  uart_result_t results_due[$];
  stim_row_t    stim_table[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  bit           calm;
  bit           rx_hold_req;

  uart_register_block_rx_fifo u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    if (error_count < MaxPrint) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic bit rx_on();
    return shadow_regs[R_CR][CR_RX_EN] && !shadow_regs[R_CR][CR_RX_DIS];
  endfunction

  function automatic bit tx_on();
    return shadow_regs[R_CR][CR_TX_EN] && !shadow_regs[R_CR][CR_TX_DIS];
  endfunction

  function automatic void latch_status();
    shadow_regs[R_CISR] |= shadow_regs[R_SR] & SR_TO_CISR;
  endfunction

  function automatic void rx_flush();
    rx_wr_ptr = 0;
    rx_level  = 0;
    shadow_regs[R_SR] |= SR_REMPTY;
    shadow_regs[R_SR] &= ~SR_RFUL;
  endfunction

  function automatic void tx_flush();
    shadow_regs[R_SR] |= SR_TEMPTY;
    shadow_regs[R_SR] &= ~SR_TFUL;
  endfunction

  function automatic void rx_enqueue(input logic [7:0] b);
    if (!rx_on()) return;
    shadow_regs[R_SR] &= ~SR_REMPTY;
    if (rx_level >= FifoDepth) begin
      shadow_regs[R_CISR] |= INT_ROVR;
    end else begin
      rx_mem[rx_wr_ptr] = b;
      rx_wr_ptr = (rx_wr_ptr + 1) % FifoDepth;
      rx_level++;
      if (rx_level == FifoDepth) shadow_regs[R_SR] |= SR_RFUL;
      else if (32'(rx_level) >= shadow_regs[R_RTRIG]) shadow_regs[R_SR] |= SR_RTRIG;
    end
    latch_status();
  endfunction

  function automatic logic [31:0] rx_dequeue();
    logic [31:0] c;
    c = '0;
    if (!rx_on()) return c;
    shadow_regs[R_SR] &= ~SR_RFUL;
    if (rx_level != 0) begin
      c = {24'd0, rx_mem[(FifoDepth + rx_wr_ptr - rx_level) % FifoDepth]};
      rx_level--;
      if (rx_level == 0) shadow_regs[R_SR] |= SR_REMPTY;
    end else begin
      shadow_regs[R_SR] |= SR_REMPTY;
    end
    if (32'(rx_level) < shadow_regs[R_RTRIG]) shadow_regs[R_SR] &= ~SR_RTRIG;
    latch_status();
    return c;
  endfunction

  function automatic uart_result_t predict_uart_item(input uart_item_t it);
    uart_result_t r;
    chan_mode_e   mode;
    logic [31:0]  cr;
    r    = '0;
    mode = chan_mode_e'(shadow_regs[R_MR][9:8]);
    case (it.op)
      OP_READ: begin
        if (it.addr == R_DATA) r.read_data = rx_dequeue();
        else if (it.addr < NRegs) r.read_data = shadow_regs[it.addr];
      end
      OP_WRITE: begin
        if (it.addr < NRegs) begin
          if (it.addr == R_IER) begin
            shadow_regs[R_IMR] |= it.wdata;
          end else if (it.addr == R_IDR) begin
            shadow_regs[R_IMR] &= ~it.wdata;
          end else if (it.addr == R_IMR) begin
            // mask is read only
          end else if (it.addr == R_CISR) begin
            shadow_regs[R_CISR] &= ~it.wdata;
          end else if (it.addr == R_DATA) begin
            case (mode)
              MODE_NORMAL: begin
                if (tx_on()) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = it.wdata[7:0];
                end
              end
              MODE_LOCAL: rx_enqueue(it.wdata[7:0]);
              default: ;
            endcase
          end else begin
            shadow_regs[it.addr] = it.wdata;
          end
          if (it.addr == R_CR) begin
            cr = shadow_regs[R_CR];
            if (cr[CR_TXRST]) tx_flush();
            if (cr[CR_RXRST]) rx_flush();
            shadow_regs[R_CR][CR_TXRST] = 1'b0;
            shadow_regs[R_CR][CR_RXRST] = 1'b0;
            if (tx_on()) begin
              shadow_regs[R_SR] |= SR_TEMPTY;
              latch_status();
            end
            cr = shadow_regs[R_CR];
            r.brk = cr[CR_STARTBRK] && !cr[CR_STOPBRK];
          end
        end
      end
      OP_RX_BYTE: begin
        if (mode == MODE_NORMAL || mode == MODE_ECHO) rx_enqueue(it.rx_byte);
        if ((mode == MODE_REMOTE || mode == MODE_ECHO) && tx_on()) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = it.rx_byte;
        end
      end
      OP_BREAK: begin
        rx_enqueue(8'd0);
        latch_status();
      end
      OP_TIMEOUT: begin
        shadow_regs[R_CISR] |= INT_TOUT;
        latch_status();
      end
      default: ;
    endcase
    r.irq = |(shadow_regs[R_IMR] & shadow_regs[R_CISR]);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic stim_row_t mk_row(input op_e op, input logic [9:0] addr,
                                       input logic [31:0] wdata, input logic [7:0] rx_byte);
    stim_row_t row;
    row.it    = '{op: op, addr: addr, wdata: wdata, rx_byte: rx_byte};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // rows whose whole result is known up front: only read_data may be nonzero
  function automatic stim_row_t mk_fixed(input op_e op, input logic [9:0] addr,
                                         input logic [31:0] wdata, input logic [7:0] rx_byte,
                                         input logic [31:0] rdata);
    stim_row_t row;
    row                = mk_row(op, addr, wdata, rx_byte);
    row.typed          = 1'b1;
    row.want.read_data = rdata;
    return row;
  endfunction

  function automatic uart_item_t random_item();
    uart_item_t  it;
    int unsigned r;
    logic [31:0] cr;
    it.op      = OP_READ;
    it.addr    = 10'($urandom_range(0, NRegs - 1));
    it.wdata   = $urandom;
    it.rx_byte = 8'($urandom);
    r          = $urandom_range(0, 99);
    if (burst_left == 0 && r < 3) burst_left = $urandom_range(10, 24);
    if (burst_left != 0) begin
      // run of 10 to 24 line bytes and breaks, which can fill and overrun the FIFO
      burst_left--;
      it.op = ($urandom_range(0, 15) == 0) ? OP_BREAK : OP_RX_BYTE;
    end else if (r < 15) begin
      it.op   = OP_WRITE;
      it.addr = R_CR;
      if ($urandom_range(0, 9) != 0) begin
        cr                = CrRun;
        cr[CR_RXRST]      = ($urandom_range(0, 9) == 0);
        cr[CR_TXRST]      = ($urandom_range(0, 9) == 0);
        cr[CR_RX_DIS]     = ($urandom_range(0, 19) == 0);
        cr[CR_TX_DIS]     = ($urandom_range(0, 19) == 0);
        cr[CR_STARTBRK]   = ($urandom_range(0, 4) == 0);
        cr[CR_STOPBRK]    = ($urandom_range(0, 9) == 0);
        it.wdata          = cr;
      end
    end else if (r < 20) begin
      it.op   = OP_WRITE;
      it.addr = R_MR;
      if ($urandom_range(0, 3) != 0) it.wdata = it.wdata & 32'h0000_0300;
    end else if (r < 42) begin
      it.op = OP_RX_BYTE;
    end else if (r < 60) begin
      it.addr = R_DATA;
    end else if (r < 68) begin
      it.op   = OP_WRITE;
      it.addr = R_DATA;
    end else if (r < 72) begin
      it.op = OP_BREAK;
    end else if (r < 76) begin
      it.op = OP_TIMEOUT;
    end else if (r < 86) begin
      if ($urandom_range(0, 4) == 0) it.addr = 10'($urandom);
    end else if (r < 90) begin
      it.op = OP_WRITE;
      case ($urandom_range(0, 2))
        0:       it.addr = R_IER;
        1:       it.addr = R_IDR;
        default: it.addr = R_CISR;
      endcase
    end else if (r < 93) begin
      it.op   = OP_WRITE;
      it.addr = R_RTRIG;
      if ($urandom_range(0, 5) != 0) it.wdata = $urandom_range(0, FifoDepth + 2);
    end else begin
      it.op = OP_WRITE;
      if ($urandom_range(0, 4) < 2) it.addr = 10'($urandom);
    end
    return it;
  endfunction

  // Offers one transaction; returns at the edge that accepted it.
  task automatic send_item(input stim_row_t row);
    uart_result_t pred;
    while (!calm && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.it.op;
    s_axis_tdata  <= {6'd0, row.it.rx_byte, row.it.wdata, row.it.addr};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    pred = predict_uart_item(row.it);
    results_due.push_back(row.typed ? row.want : pred);
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int unsigned k = 1; k < HoldCycles; k++) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // inputs only move at rising edges, so the negedge view is what the next edge sees
  always @(negedge clk_i) begin
    uart_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        report_error($sformatf("unexpected result tdata=%h", m_axis_tdata));
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[31:0] !== want.read_data)
          report_error($sformatf("read_data %h, want %h", m_axis_tdata[31:0], want.read_data));
        if (m_axis_tdata[32] !== want.irq)
          report_error($sformatf("irq %b, want %b", m_axis_tdata[32], want.irq));
        if (m_axis_tdata[33] !== want.tx_valid)
          report_error($sformatf("tx_valid %b, want %b", m_axis_tdata[33], want.tx_valid));
        if (m_axis_tdata[41:34] !== want.tx_byte)
          report_error($sformatf("tx_byte %h, want %h", m_axis_tdata[41:34], want.tx_byte));
        if (m_axis_tdata[42] !== want.brk)
          report_error($sformatf("break_request %b, want %b", m_axis_tdata[42], want.brk));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main flow
  initial begin
    uart_item_t rnd_it;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    error_count   = 0;
    cycle_count   = 0;
    burst_left    = 0;
    calm          = 1'b0;
    rx_hold_req   = 1'b0;

    for (int i = 0; i < NRegs; i++) shadow_regs[i] = '0;
    for (int i = 0; i < FifoDepth; i++) rx_mem[i] = '0;
    shadow_regs[R_CR]    = CR_RESET;
    shadow_regs[R_BRGR]  = BRGR_RESET;
    shadow_regs[R_RTRIG] = TRIG_RESET;
    shadow_regs[R_TTRIG] = TRIG_RESET;
    shadow_regs[R_SR]    = SR_RESET;
    rx_wr_ptr            = 0;
    rx_level             = 0;

    // reset values, unmapped space, receiver still disabled
    stim_table.push_back(mk_fixed(OP_READ, R_CR, '0, '0, CR_RESET));
    stim_table.push_back(mk_fixed(OP_READ, R_SR, '0, '0, SR_RESET));
    stim_table.push_back(mk_fixed(OP_READ, R_RTRIG, '0, '0, TRIG_RESET));
    stim_table.push_back(mk_fixed(OP_READ, 10'h3FF, '0, '0, '0));
    stim_table.push_back(mk_fixed(OP_WRITE, 10'd18, 32'hFFFF_FFFF, 8'hFF, '0));
    stim_table.push_back(mk_fixed(OP_RX_BYTE, '0, '0, 8'h55, '0));
    stim_table.push_back(mk_fixed(OP_READ, R_DATA, '0, '0, '0));
    // enable with a break request, open the mask, try the read-only mask
    stim_table.push_back(mk_row(OP_WRITE, R_CR, CrRun | (32'd1 << CR_STARTBRK), '0));
    stim_table.push_back(mk_row(OP_WRITE, R_IER, 32'hFFFF_FFFF, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_IMR, '0, '0));
    stim_table.push_back(mk_row(OP_READ, R_IMR, '0, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_RTRIG, 32'd2, '0));
    // line traffic, then drain past empty
    stim_table.push_back(mk_row(OP_RX_BYTE, '0, '0, 8'hFF));
    stim_table.push_back(mk_row(OP_RX_BYTE, '0, '0, 8'h00));
    stim_table.push_back(mk_row(OP_BREAK, '0, '0, 8'hA7));
    stim_table.push_back(mk_row(OP_TIMEOUT, '0, '0, '0));
    for (int i = 0; i < 4; i++) stim_table.push_back(mk_row(OP_READ, R_DATA, '0, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_CISR, 32'hFFFF_FFFF, '0));
    // every channel mode
    stim_table.push_back(mk_row(OP_WRITE, R_MR, 32'h0000_0200, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_DATA, 32'hFFFF_FFA5, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_MR, 32'h0000_0100, '0));
    stim_table.push_back(mk_row(OP_RX_BYTE, '0, '0, 8'h3C));
    stim_table.push_back(mk_row(OP_WRITE, R_MR, 32'h0000_0300, '0));
    stim_table.push_back(mk_row(OP_RX_BYTE, '0, '0, 8'hC3));
    stim_table.push_back(mk_row(OP_WRITE, R_MR, '0, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_DATA, 32'h0000_005A, '0));
    stim_table.push_back(mk_row(OP_WRITE, R_CR,
                                CrRun | (32'd1 << CR_RXRST) | (32'd1 << CR_TXRST), '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send_item(stim_table[i]);

    for (int unsigned n = 0; n < RandItems; n++) begin
      calm = (n >= 300 && n < 550);
      if (n == 700) rx_hold_req = 1'b1;
      if (n == 900) begin
        // let the pipe run dry before going on
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (results_due.size() != 0);
      end
      rnd_it = random_item();
      send_item(mk_row(rnd_it.op, rnd_it.addr, rnd_it.wdata, rnd_it.rx_byte));
      stim_table.delete();
    end

    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== uart_register_block_rx_fifo.f =====
src/urbrf_pkg.sv
src/urbrf_ram.sv
src/uart_register_block_rx_fifo.sv
verif/tb_top.sv
